/* sv/upv_pkg.sv */
package upv_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int NUM_LANES   = 3;
   localparam int LANE_STAGES = FRAC_BITS + 1;
   localparam int NUM_STG     = LANE_STAGES + 3;
   localparam int OUT_STG     = NUM_STG - 1;

   localparam int DIR_W  = 16;
   localparam int ML_W   = 15;
   localparam int THR_W  = 2 * ML_W;
   localparam int SQ_W   = 2 * DIR_W - 1;
   localparam int S_W    = SQ_W + 1;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int ACC_W  = 2 * (FRAC_BITS + 2) + S_W + 2;
   localparam int R_SHIFT = 2 * FRAC_BITS + 2;

   localparam logic [ML_W-1:0] MIN_LENGTH_RST = ML_W'(2);
   localparam logic signed [DIR_W-1:0] ONE = DIR_W'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][S_W-1:0]  s;
      logic [NUM_LANES-1:0][SQ_W-1:0] mag2;
      logic [NUM_LANES-1:0]           neg;
      axis_type                       axis;
      logic                           degen;
   } cand_type;

   typedef struct packed {
      logic [NUM_LANES-1:0] neg;
      axis_type             axis;
      logic                 degen;
   } tag_type;

endpackage

/* sv/upv_front.sv */
module upv_front (
   input  logic                        clock,
   input  logic [1:0]                  en,
   input  logic signed [15:0]          dir_x,
   input  logic signed [15:0]          dir_y,
   input  logic signed [15:0]          dir_z,
   input  logic [upv_pkg::THR_W-1:0]   thr,
   output upv_pkg::cand_type           cand
);
   import upv_pkg::*;

   logic [SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   logic             sgx_ff, sgy_ff, sgz_ff;
   logic [2*DIR_W-1:0] px, py, pz;
   logic [S_W-1:0]   s0, s1, s2;
   logic             ok0, ok1, ok2;
   cand_type         cand_in, cand_ff;

   assign px = 32'($signed(dir_x) * $signed(dir_x));
   assign py = 32'($signed(dir_y) * $signed(dir_y));
   assign pz = 32'($signed(dir_z) * $signed(dir_z));

   // squares
   always_ff @(posedge clock) begin
      if (en[0]) begin
         sqx_ff <= px[SQ_W-1:0];
         sqy_ff <= py[SQ_W-1:0];
         sqz_ff <= pz[SQ_W-1:0];
         sgx_ff <= dir_x[DIR_W-1];
         sgy_ff <= dir_y[DIR_W-1];
         sgz_ff <= dir_z[DIR_W-1];
      end
   end

   assign s0 = S_W'(sqy_ff) + S_W'(sqz_ff);
   assign s1 = S_W'(sqz_ff) + S_W'(sqx_ff);
   assign s2 = S_W'(sqx_ff) + S_W'(sqy_ff);

   assign ok0 = (s0 != '0) && (s0 >= S_W'(thr));
   assign ok1 = (s1 != '0) && (s1 >= S_W'(thr));
   assign ok2 = (s2 != '0) && (s2 >= S_W'(thr));

   // candidate pick and lane setup
   always_comb begin
      cand_in = '0;
      cand_in.degen = 1'b0;
      if (ok0) begin
         cand_in.axis = AXIS_X;
      end else if (ok1) begin
         cand_in.axis = AXIS_Y;
      end else if (ok2) begin
         cand_in.axis = AXIS_Z;
      end else begin
         cand_in.axis  = AXIS_X;
         cand_in.degen = 1'b1;
      end
      case (cand_in.axis)
         AXIS_X: begin
            cand_in.s       = {s0, s0, s0};
            cand_in.mag2[1] = sqz_ff;
            cand_in.neg[1]  = sgz_ff;
            cand_in.mag2[2] = sqy_ff;
            cand_in.neg[2]  = !sgy_ff;
         end
         AXIS_Y: begin
            cand_in.s       = {s1, s1, s1};
            cand_in.mag2[0] = sqz_ff;
            cand_in.neg[0]  = !sgz_ff;
            cand_in.mag2[2] = sqx_ff;
            cand_in.neg[2]  = sgx_ff;
         end
         AXIS_Z: begin
            cand_in.s       = {s2, s2, s2};
            cand_in.mag2[0] = sqy_ff;
            cand_in.neg[0]  = sgy_ff;
            cand_in.mag2[1] = sqx_ff;
            cand_in.neg[1]  = !sgx_ff;
         end
         default: begin
            cand_in.s = {s0, s0, s0};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cand_ff <= cand_in;
      end
   end

   assign cand = cand_ff;

endmodule

/* sv/upv_lane.sv */
module upv_lane (
   input  logic                             clock,
   input  logic [upv_pkg::LANE_STAGES-1:0]  en,
   input  logic [upv_pkg::S_W-1:0]          s_in,
   input  logic [upv_pkg::SQ_W-1:0]         mag2_in,
   output logic [upv_pkg::Q_W-1:0]          q_out
);
   import upv_pkg::*;

   logic [Q_W-1:0]          q_ff  [LANE_STAGES];
   logic signed [ACC_W-1:0] p_ff  [LANE_STAGES];
   logic signed [ACC_W-1:0] d_ff  [LANE_STAGES];
   logic [S_W-1:0]          s_ff  [LANE_STAGES];
   logic [SQ_W-1:0]         m2_ff [LANE_STAGES];

   logic [Q_W-1:0]          q_prv  [LANE_STAGES];
   logic signed [ACC_W-1:0] p_prv  [LANE_STAGES];
   logic signed [ACC_W-1:0] d_prv  [LANE_STAGES];
   logic [S_W-1:0]          s_prv  [LANE_STAGES];
   logic [SQ_W-1:0]         m2_prv [LANE_STAGES];

   // one result bit per stage, msb first; p tracks (2q-1)^2*s, d tracks (2q-1)*s
   for (genvar j = 0; j < LANE_STAGES; j++) begin : g_stg
      localparam int B = FRAC_BITS - j;
      logic signed [ACC_W-1:0] s_ext, r_ext, p_try;
      logic                    take;

      if (j == 0) begin : g_first
         assign s_prv[j]  = s_in;
         assign m2_prv[j] = mag2_in;
         assign q_prv[j]  = '0;
         assign p_prv[j]  = $signed({{(ACC_W-S_W){1'b0}}, s_in});
         assign d_prv[j]  = -$signed({{(ACC_W-S_W){1'b0}}, s_in});
      end else begin : g_next
         assign s_prv[j]  = s_ff[j-1];
         assign m2_prv[j] = m2_ff[j-1];
         assign q_prv[j]  = q_ff[j-1];
         assign p_prv[j]  = p_ff[j-1];
         assign d_prv[j]  = d_ff[j-1];
      end

      assign s_ext = $signed({{(ACC_W-S_W){1'b0}}, s_prv[j]});
      assign r_ext = $signed({{(ACC_W-SQ_W){1'b0}}, m2_prv[j]}) <<< R_SHIFT;
      assign p_try = p_prv[j] + (d_prv[j] <<< (B + 2)) + (s_ext <<< (2 * B + 2));
      // saturate at one: no bit may be added past it
      assign take  = !q_prv[j][FRAC_BITS] && (p_try <= r_ext);

      always_ff @(posedge clock) begin
         if (en[j]) begin
            s_ff[j]  <= s_prv[j];
            m2_ff[j] <= m2_prv[j];
            if (take) begin
               q_ff[j] <= q_prv[j] | (Q_W'(1) << B);
               p_ff[j] <= p_try;
               d_ff[j] <= d_prv[j] + (s_ext <<< (B + 1));
            end else begin
               q_ff[j] <= q_prv[j];
               p_ff[j] <= p_prv[j];
               d_ff[j] <= d_prv[j];
            end
         end
      end
   end

   assign q_out = q_ff[LANE_STAGES-1];

endmodule

/* sv/unit_perpendicular_vector_top.sv */
// Unit perpendicular vector, signed Q1.14 in and out.
//
// Input channel req_*: one direction (req_dir_x/y/z) per transfer on
// req_valid/req_ready. Result channel rsp_*: one perpendicular unit vector
// per input, with the crossed axis (0 X, 1 Y, 2 Z) and a degenerate flag
// (all candidates shorter than min_length: vector and axis then zero).
// csr_wr_en/csr_wr_data write min_length; write only while no item is in
// flight.
//
// Two stages form the squares and pick the candidate, then three lanes run
// one 15-stage digit recurrence each (one result bit per stage), then an
// output register. Throughput: one item per cycle while rsp_ready is high.
//
// Reset (synchronous, active high) empties the pipeline and sets min_length
// to 2. When the receiver holds rsp_ready low, the result stays on the ports
// and items behind it move up into empty stages; req_ready falls only when
// every stage holds an item.
module unit_perpendicular_vector_top
   import upv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [15:0]        req_dir_x,
   input  logic signed [15:0]        req_dir_y,
   input  logic signed [15:0]        req_dir_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_perp_x,
   output logic signed [15:0]        rsp_perp_y,
   output logic signed [15:0]        rsp_perp_z,
   output logic [1:0]                rsp_axis_used,
   output logic                      rsp_degenerate,
   input  logic                      csr_wr_en,
   input  logic [14:0]               csr_wr_data
);

   logic [ML_W-1:0]   ml_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG:0]  en;
   cand_type          cand;
   tag_type           tag_ff [LANE_STAGES];
   logic [Q_W-1:0]    q [NUM_LANES];
   logic signed [DIR_W-1:0] perp_in [NUM_LANES];
   logic signed [DIR_W-1:0] perp_ff [NUM_LANES];
   axis_type          axis_ff;
   logic              degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_ff  <= MIN_LENGTH_RST;
         thr_ff <= THR_W'(MIN_LENGTH_RST) * THR_W'(MIN_LENGTH_RST);
      end else begin
         if (csr_wr_en) begin
            ml_ff <= csr_wr_data;
         end
         thr_ff <= THR_W'(ml_ff) * THR_W'(ml_ff);
      end
   end

   // stage advances when empty or when the next one advances
   always_comb begin
      en[NUM_STG] = rsp_ready;
      for (int k = NUM_STG - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in = {vld_ff[NUM_STG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[OUT_STG];

   upv_front u_front (
      .clock (clock),
      .en    (en[1:0]),
      .dir_x (req_dir_x),
      .dir_y (req_dir_y),
      .dir_z (req_dir_z),
      .thr   (thr_ff),
      .cand  (cand)
   );

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      upv_lane u_lane (
         .clock   (clock),
         .en      (en[2 +: LANE_STAGES]),
         .s_in    (cand.s[l]),
         .mag2_in (cand.mag2[l]),
         .q_out   (q[l])
      );
   end

   // sign, axis and flag ride alongside the lanes
   always_ff @(posedge clock) begin
      if (en[2]) begin
         tag_ff[0] <= '{neg: cand.neg, axis: cand.axis, degen: cand.degen};
      end
      for (int j = 1; j < LANE_STAGES; j++) begin
         if (en[2+j]) begin
            tag_ff[j] <= tag_ff[j-1];
         end
      end
   end

   // merge
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (tag_ff[LANE_STAGES-1].degen) begin
            perp_in[l] = '0;
         end else if (tag_ff[LANE_STAGES-1].neg[l]) begin
            perp_in[l] = -$signed({1'b0, q[l]});
         end else begin
            perp_in[l] = $signed({1'b0, q[l]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUT_STG]) begin
         perp_ff  <= perp_in;
         axis_ff  <= tag_ff[LANE_STAGES-1].degen ? AXIS_X : tag_ff[LANE_STAGES-1].axis;
         degen_ff <= tag_ff[LANE_STAGES-1].degen;
      end
   end

   assign rsp_perp_x     = perp_ff[0];
   assign rsp_perp_y     = perp_ff[1];
   assign rsp_perp_z     = perp_ff[2];
   assign rsp_axis_used  = axis_ff;
   assign rsp_degenerate = degen_ff;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_perp_x == '0 && rsp_perp_y == '0 && rsp_perp_z == '0 &&
          rsp_axis_used == AXIS_X))
      else $error("degenerate result not zero");

   a_perp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_perp_x <= ONE && rsp_perp_x >= -ONE &&
          rsp_perp_y <= ONE && rsp_perp_y >= -ONE &&
          rsp_perp_z <= ONE && rsp_perp_z >= -ONE))
      else $error("result component beyond one");

   a_axis_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_degenerate) |->
         ((rsp_axis_used == AXIS_X && rsp_perp_x == '0) ||
          (rsp_axis_used == AXIS_Y && rsp_perp_y == '0) ||
          (rsp_axis_used == AXIS_Z && rsp_perp_z == '0)))
      else $error("component on crossed axis not zero");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transfer lost at entry");

endmodule
